// ===== hdl/srfs_pkg.sv =====
// Package with shared constants, types and a helper function of the slot scheduler.
`default_nettype none
package srfs_pkg;

  localparam int unsigned SLOT_MAX       = 64;
  localparam int unsigned SLOT_COUNT_DEF = 64;
  localparam int unsigned IDX_W          = 6;
  localparam int unsigned KIND_W         = 3;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PADDR_W        = 3;
  localparam int unsigned PDATA_W        = 32;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_SIGNAL = 2'd1,
    OP_UNSUB  = 2'd2,
    OP_PASS   = 2'd3
  } op_e_t;

  typedef enum logic [2:0] {
    CMD_CREATE,
    CMD_CREATE_FAIL,
    CMD_SIGNAL,
    CMD_UNSUB,
    CMD_PASS
  } cmd_e_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATED       = 3'd0,
    KIND_CREATE_FAILED = 3'd1,
    KIND_SIGNAL_DONE   = 3'd2,
    KIND_SERVICE_RUN   = 3'd3,
    KIND_SERVICE_END   = 3'd4,
    KIND_PASS_EMPTY    = 3'd5
  } kind_e_t;

  typedef enum logic {
    BK_IDLE,
    BK_PASS
  } back_state_t;

  typedef enum logic {
    REG_NOTIFY_ENABLED = 1'b0
  } reg_idx_t;

  typedef struct packed {
    cmd_e_t           cmd;
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             has_end;
  } cmd_t;

  function automatic logic [IDX_W-1:0] lowest_set(logic [SLOT_MAX-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int k = SLOT_MAX - 1; k >= 0; k--) begin
      if (v[k]) begin
        r = IDX_W'(k);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/srfs_if.sv =====
// Valid/ready channel interfaces for input words and result words.
`default_nettype none
interface srfs_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [srfs_pkg::IDX_W-1:0]  slot_index;
  logic                        has_handler;
  logic                        has_end_handler;

  modport source (output valid, operation, slot_index, has_handler, has_end_handler,
                  input ready);
  modport sink (input valid, operation, slot_index, has_handler, has_end_handler,
                output ready);
endinterface

interface srfs_out_if;
  logic                         valid;
  logic                         ready;
  logic [srfs_pkg::KIND_W-1:0]  kind;
  logic [srfs_pkg::IDX_W-1:0]   result_slot;
  logic                         notify;
  logic                         end_handler_present;
  logic                         pending_any;
  logic                         last;

  modport source (output valid, kind, result_slot, notify, end_handler_present,
                  pending_any, last, input ready);
  modport sink (input valid, kind, result_slot, notify, end_handler_present,
                pending_any, last, output ready);
endinterface
`default_nettype wire

// ===== hdl/srfs_front.sv =====
// Front end that accepts input words and classifies them into commands.
`default_nettype none
module srfs_front #(
  parameter int unsigned SLOT_COUNT = srfs_pkg::SLOT_COUNT_DEF
) (
  srfs_in_if.sink          in_chan,
  output logic             push_valid,
  input  logic             push_ready,
  output srfs_pkg::cmd_t   push_cmd
);

  srfs_pkg::op_e_t op;

  assign op             = srfs_pkg::op_e_t'(in_chan.operation);
  assign push_valid     = in_chan.valid;
  assign in_chan.ready  = push_ready;

  always_comb begin
    push_cmd.idx      = in_chan.slot_index;
    push_cmd.has_end  = in_chan.has_end_handler;
    push_cmd.in_range = ((srfs_pkg::IDX_W + 1)'(in_chan.slot_index)
                         < (srfs_pkg::IDX_W + 1)'(SLOT_COUNT));
    unique case (op)
      srfs_pkg::OP_CREATE: begin
        push_cmd.cmd = in_chan.has_handler ? srfs_pkg::CMD_CREATE : srfs_pkg::CMD_CREATE_FAIL;
      end
      srfs_pkg::OP_SIGNAL: begin
        push_cmd.cmd = srfs_pkg::CMD_SIGNAL;
      end
      srfs_pkg::OP_UNSUB: begin
        push_cmd.cmd = srfs_pkg::CMD_UNSUB;
      end
      default: begin
        push_cmd.cmd = srfs_pkg::CMD_PASS;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/srfs_queue.sv =====
// Short command queue between the front end and the back end.
`default_nettype none
module srfs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  srfs_pkg::cmd_t   push_cmd,
  output logic             pop_valid,
  input  logic             pop_ready,
  output srfs_pkg::cmd_t   pop_cmd
);

  srfs_pkg::cmd_t                   mem_r [srfs_pkg::QUEUE_DEPTH];
  logic [srfs_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [srfs_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [srfs_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                             do_push, do_pop;

  assign push_ready = (count_r != srfs_pkg::QCNT_W'(srfs_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == srfs_pkg::QPTR_W'(srfs_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == srfs_pkg::QPTR_W'(srfs_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/srfs_back.sv =====
// Back end that holds the slot table, runs commands and service passes, and registers results.
`default_nettype none
module srfs_back #(
  parameter int unsigned SLOT_COUNT = srfs_pkg::SLOT_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             notify_en,
  input  logic             q_valid,
  output logic             q_ready,
  input  srfs_pkg::cmd_t   q_cmd,
  srfs_out_if.source       out_chan
);

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);

  srfs_pkg::back_state_t           state_r, state_nxt;
  logic [SLOT_COUNT-1:0]           pend_r, pend_nxt;
  logic [SLOT_COUNT-1:0]           free_r, free_nxt;
  logic [SLOT_COUNT-1:0]           ending_r, ending_nxt;
  logic [SLOT_COUNT-1:0]           endh_r, endh_nxt;
  logic                            out_valid_r, out_valid_nxt;
  srfs_pkg::kind_e_t               kind_r, kind_nxt;
  logic [srfs_pkg::IDX_W-1:0]      slot_r, slot_nxt;
  logic                            notify_r, notify_nxt;
  logic                            endhp_r, endhp_nxt;
  logic                            pany_r, pany_nxt;
  logic                            last_r, last_nxt;
  logic                            out_free, pop, svc, load;
  logic [SLOT_W-1:0]               lo_pend, lo_free, sidx;
  logic [SLOT_COUNT-1:0]           rest;

  assign out_free = !out_valid_r || out_chan.ready;
  assign pop      = (state_r == srfs_pkg::BK_IDLE) && q_valid && out_free;
  assign q_ready  = pop;
  assign svc      = out_free && ((state_r == srfs_pkg::BK_PASS)
                    || (pop && (q_cmd.cmd == srfs_pkg::CMD_PASS) && (pend_r != '0)));
  assign load     = svc || pop;
  assign lo_pend  = SLOT_W'(srfs_pkg::lowest_set(srfs_pkg::SLOT_MAX'(pend_r)));
  assign lo_free  = SLOT_W'(srfs_pkg::lowest_set(srfs_pkg::SLOT_MAX'(free_r)));
  assign sidx     = q_cmd.idx[SLOT_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    free_nxt   = free_r;
    ending_nxt = ending_r;
    endh_nxt   = endh_r;
    kind_nxt   = kind_r;
    slot_nxt   = slot_r;
    notify_nxt = 1'b0;
    endhp_nxt  = 1'b0;
    pany_nxt   = |pend_r;
    last_nxt   = 1'b1;
    rest       = pend_r;
    if (svc) begin
      rest          = pend_r;
      rest[lo_pend] = 1'b0;
      pend_nxt      = rest;
      slot_nxt      = srfs_pkg::IDX_W'(lo_pend);
      last_nxt      = (rest == '0);
      pany_nxt      = (rest != '0);
      state_nxt     = (rest == '0) ? srfs_pkg::BK_IDLE : srfs_pkg::BK_PASS;
      if (ending_r[lo_pend]) begin
        ending_nxt[lo_pend] = 1'b0;
        free_nxt[lo_pend]   = 1'b1;
        kind_nxt            = srfs_pkg::KIND_SERVICE_END;
        endhp_nxt           = endh_r[lo_pend];
      end else begin
        kind_nxt = srfs_pkg::KIND_SERVICE_RUN;
      end
    end else if (pop) begin
      unique case (q_cmd.cmd)
        srfs_pkg::CMD_CREATE: begin
          if (free_r != '0) begin
            free_nxt[lo_free] = 1'b0;
            endh_nxt[lo_free] = q_cmd.has_end;
            kind_nxt          = srfs_pkg::KIND_CREATED;
            slot_nxt          = srfs_pkg::IDX_W'(lo_free);
          end else begin
            kind_nxt = srfs_pkg::KIND_CREATE_FAILED;
            slot_nxt = '0;
          end
        end
        srfs_pkg::CMD_CREATE_FAIL: begin
          kind_nxt = srfs_pkg::KIND_CREATE_FAILED;
          slot_nxt = '0;
        end
        srfs_pkg::CMD_SIGNAL, srfs_pkg::CMD_UNSUB: begin
          kind_nxt = srfs_pkg::KIND_SIGNAL_DONE;
          slot_nxt = q_cmd.idx;
          if (q_cmd.in_range) begin
            notify_nxt     = !pend_r[sidx] && notify_en;
            pend_nxt[sidx] = 1'b1;
            pany_nxt       = 1'b1;
            if (q_cmd.cmd == srfs_pkg::CMD_UNSUB) begin
              free_nxt[sidx]   = 1'b0;
              ending_nxt[sidx] = 1'b1;
            end
          end
        end
        default: begin
          kind_nxt = srfs_pkg::KIND_PASS_EMPTY;
          slot_nxt = '0;
          pany_nxt = 1'b0;
        end
      endcase
    end
    out_valid_nxt = load || (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srfs_pkg::BK_IDLE;
      pend_r      <= '0;
      free_r      <= '1;
      ending_r    <= '0;
      endh_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      free_r      <= free_nxt;
      ending_r    <= ending_nxt;
      endh_r      <= endh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= kind_nxt;
      slot_r   <= slot_nxt;
      notify_r <= notify_nxt;
      endhp_r  <= endhp_nxt;
      pany_r   <= pany_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.kind                = kind_r;
  assign out_chan.result_slot         = slot_r;
  assign out_chan.notify              = notify_r;
  assign out_chan.end_handler_present = endhp_r;
  assign out_chan.pending_any         = pany_r;
  assign out_chan.last                = last_r;

endmodule
`default_nettype wire

// ===== hdl/slot_request_flag_scheduler.sv =====
// Top level of the slot request flag scheduler with its configuration port.
// An accepted input word is queued; its result is registered when the back end pops it.
// In the back end, create, signal and unsubscribe go one word per cycle when not stalled.
// A service pass serves pending slots by priority encoder, one result per unstalled cycle.
// Synchronous active-low reset frees all slots and clears pending and end-handler bits.
// Reset also clears the notification enable; no clearing pass follows reset.
`default_nettype none
module slot_request_flag_scheduler #(
  parameter int unsigned SLOT_COUNT = srfs_pkg::SLOT_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  srfs_in_if.sink                        in_chan,
  srfs_out_if.source                     out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [srfs_pkg::PADDR_W-1:0]   paddr,
  input  logic [srfs_pkg::PDATA_W-1:0]   pwdata,
  output logic [srfs_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic               notify_en_r, notify_en_nxt;
  logic               push_valid, push_ready, q_valid, q_ready;
  srfs_pkg::cmd_t     push_cmd, q_cmd;
  srfs_pkg::reg_idx_t reg_sel;
  logic               reg_hit;

  assign pready  = 1'b1;
  assign reg_sel = srfs_pkg::reg_idx_t'(paddr[2]);
  assign reg_hit = (paddr[srfs_pkg::PADDR_W-1:2] == '0)
                   && (reg_sel == srfs_pkg::REG_NOTIFY_ENABLED);

  always_comb begin
    notify_en_nxt = notify_en_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      notify_en_nxt = pwdata[0];
    end
    prdata = reg_hit ? srfs_pkg::PDATA_W'(notify_en_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      notify_en_r <= 1'b0;
    end else begin
      notify_en_r <= notify_en_nxt;
    end
  end

  srfs_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  srfs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  srfs_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .notify_en (notify_en_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire
